// ----- rtl/core/row_segment_edge_labeler_assert.svh -----
// Assertion macros shared by the row segment edge labeler modules.
// Needs nothing else; each asserting module includes this file.
`ifndef ROW_SEGMENT_EDGE_LABELER_ASSERT_SVH
`define ROW_SEGMENT_EDGE_LABELER_ASSERT_SVH

// Implication checked on every rising clock edge outside of reset.
`define RSEL_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Same check with the project clock and reset names.
`define RSEL_ASSERT(lbl, prop, msg) \
  `RSEL_ASSERT_CLK(lbl, clk, rst, prop, msg)

`endif

// ----- rtl/core/rsel_pkg.sv -----
// Package for the row segment edge labeler: sizes, register indexes,
// the result record and the dimension clamp. Depends on nothing.
package rsel_pkg;

  // Largest image dimensions that the counters support.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Field widths of the registers and the stream.
  localparam int REG_W   = 13;
  localparam int PIXEL_W = 8;
  localparam int LABEL_W = 13;
  localparam int SUM_W   = 25;

  // Counter widths follow from the largest dimensions.
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int IDX_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W = (IDX_MAX_W + 1 > REG_W) ? IDX_MAX_W + 1 : REG_W;

  // Stream widths.
  localparam int TDATA_W = 3 * LABEL_W + SUM_W;
  localparam int TUSER_W = 2;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd1;

  // One result item.
  typedef struct packed {
    logic [SUM_W-1:0]   sum_segments;
    logic [LABEL_W-1:0] max_segments;
    logic               frame_done;
    logic [LABEL_W-1:0] row_segments;
    logic               row_done;
    logic [LABEL_W-1:0] relative_label;
  } result_t;

  // A zero dimension acts as one, and an oversized one as the maximum.
  function automatic logic [CMP_W-1:0] clamp_dim(input logic [REG_W-1:0] v,
                                                 input logic [CMP_W-1:0] hi);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    if (v == '0) begin
      clamp_dim = CMP_W'(1);
    end else if (ext > hi) begin
      clamp_dim = hi;
    end else begin
      clamp_dim = ext;
    end
  endfunction

endpackage

// ----- rtl/core/rsel_in_stage.sv -----
// Input register of the row segment edge labeler: holds the pixel bit.
// Depends on rsel_pkg.
module rsel_in_stage
  import rsel_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [PIXEL_W-1:0] s_tdata,    // [7:0] pixel
  input  logic               out_free,
  output logic               in_valid,
  output logic               in_bit,
  output logic               fire
);

  // The held pixel moves on whenever the result register can take it.
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Only bit 0 of the pixel matters.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_bit <= s_tdata[0];
    end
  end

endmodule

// ----- rtl/core/rsel_label_core.sv -----
// Labeling logic: configuration registers, row and frame counters and the
// result of one pixel. Depends on rsel_pkg and the assertion macros.
`include "row_segment_edge_labeler_assert.svh"
module rsel_label_core
  import rsel_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 fire,
  input  logic                 in_bit,
  output result_t              result
);

  logic [REG_W-1:0]   row_width;
  logic [REG_W-1:0]   row_count;
  logic               previous_bit;
  logic [LABEL_W-1:0] edge_count;
  logic [COL_W-1:0]   column_index;
  logic [ROW_W-1:0]   row_index;
  logic [LABEL_W-1:0] running_max;
  logic [SUM_W-1:0]   running_sum;

  logic [CMP_W-1:0]   w_eff;
  logic [CMP_W-1:0]   h_eff;
  logic [LABEL_W-1:0] edge_count_next;
  logic [LABEL_W-1:0] segs;
  logic               last_col;
  logic               last_row;
  logic [LABEL_W-1:0] running_max_next;
  logic [SUM_W-1:0]   running_sum_next;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= REG_W'(640);
      row_count <= REG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_WIDTH: row_width <= cfg_data;
        REG_ROW_COUNT: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective dimensions and end-of-row and end-of-frame detection.
  assign w_eff    = clamp_dim(row_width, CMP_W'(MAX_WIDTH));
  assign h_eff    = clamp_dim(row_count, CMP_W'(MAX_HEIGHT));
  assign last_col = (CMP_W'(column_index) + CMP_W'(1)) >= w_eff;
  assign last_row = (CMP_W'(row_index) + CMP_W'(1)) >= h_eff;

  // The label starts at the first bit and counts every bit change.
  always_comb begin
    if (column_index == '0) begin
      edge_count_next = LABEL_W'(in_bit);
    end else begin
      edge_count_next = edge_count + LABEL_W'(previous_bit ^ in_bit);
    end
  end

  // Row count includes the last pixel's bit; frame statistics follow.
  assign segs             = edge_count_next + LABEL_W'(in_bit);
  assign running_max_next = (segs > running_max) ? segs : running_max;
  assign running_sum_next = running_sum + SUM_W'(segs);

  always_comb begin
    result                = '0;
    result.relative_label = edge_count_next;
    if (last_col) begin
      result.row_done     = 1'b1;
      result.row_segments = segs;
      if (last_row) begin
        result.frame_done   = 1'b1;
        result.max_segments = running_max_next;
        result.sum_segments = running_sum_next;
      end
    end
  end

  // Counter state advances once per transaction that leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_bit <= 1'b0;
      edge_count   <= '0;
      column_index <= '0;
      row_index    <= '0;
      running_max  <= '0;
      running_sum  <= '0;
    end else if (fire) begin
      previous_bit <= in_bit;
      edge_count   <= edge_count_next;
      if (!last_col) begin
        column_index <= column_index + COL_W'(1);
      end else begin
        column_index <= '0;
        if (!last_row) begin
          row_index   <= row_index + ROW_W'(1);
          running_max <= running_max_next;
          running_sum <= running_sum_next;
        end else begin
          row_index   <= '0;
          running_max <= '0;
          running_sum <= '0;
        end
      end
    end
  end

  `RSEL_ASSERT(a_row_end_wraps_column, fire && result.row_done |=> column_index == '0, "column index not cleared at row end")
  `RSEL_ASSERT(a_column_steps, fire && !result.row_done |=> column_index == COL_W'($past(column_index) + COL_W'(1)), "column index did not step by one")
  `RSEL_ASSERT(a_frame_ends_row, result.frame_done |-> result.row_done, "frame end without row end")

endmodule

// ----- rtl/core/rsel_out_stage.sv -----
// Result register of the row segment edge labeler and the stream packing.
// Depends on rsel_pkg.
module rsel_out_stage
  import rsel_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  result_t            result,
  output logic               out_free,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,    // relative_label, row_segments, max_segments, sum_segments
  output logic [TUSER_W-1:0] m_tuser     // row_done, frame_done
);

  result_t result_r;

  // The register takes a new result when empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      result_r <= result;
    end
  end

  // Pack the fields, first field in the lowest bits.
  assign m_tdata = {result_r.sum_segments, result_r.max_segments,
                    result_r.row_segments, result_r.relative_label};
  assign m_tuser = {result_r.frame_done, result_r.row_done};

endmodule

// ----- rtl/core/row_segment_edge_labeler.sv -----
// Row segment edge labeler: takes one binary pixel per cycle in raster order
// and returns one result transaction per pixel through two register stages
// (input register, then result register); both stages advance whenever the
// result register is free, so the sustained rate is one pixel per clock,
// limited only by the downstream tready. No clearing pass is needed after
// reset. Configure row_width and row_count only while no pixel is in flight.
// Top level; depends on rsel_pkg, rsel_in_stage, rsel_label_core, rsel_out_stage.
`include "row_segment_edge_labeler_assert.svh"
module row_segment_edge_labeler
  import rsel_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [PIXEL_W-1:0]   s_tdata,    // [7:0] pixel
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,    // [12:0] relative_label, [25:13] row_segments,
                                           // [38:26] max_segments, [63:39] sum_segments
  output logic [TUSER_W-1:0]   m_tuser     // [0] row_done, [1] frame_done
);

  logic    out_free;
  logic    in_valid;
  logic    in_bit;
  logic    fire;
  result_t result;

  // Input register.
  rsel_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .out_free (out_free),
    .in_valid (in_valid),
    .in_bit   (in_bit),
    .fire     (fire)
  );

  // Label and counter logic.
  rsel_label_core u_label_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .in_bit    (in_bit),
    .result    (result)
  );

  // Result register.
  rsel_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .result   (result),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `RSEL_ASSERT(a_ready_when_out_empty, !m_tvalid |-> s_tready, "input stalled while result register is empty")

endmodule
